// ===== design/knn_sel_pkg.sv =====
// ----------------------------------------------------------------------------
// knn_sel_pkg: shared types and constants of the k-nearest-neighbor selector
// Field widths, register indexes, opcodes and the stored point layout.
// ----------------------------------------------------------------------------
package knn_sel_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int MAX_POINTS_DEF    = 4096;
  localparam int MAX_NEIGHBORS_DEF = 16;

  // Field widths fixed by the interface.
  localparam int COORD_W  = 24;
  localparam int INDEX_W  = 12;
  localparam int DIST_W   = 50;
  localparam int RANK_W   = 4;
  localparam int NCOUNT_W = 5;
  localparam int PCOUNT_W = 13;
  localparam int COUNT_W  = 13;

  // Magnitude of a coordinate difference always fits in the coordinate width.
  localparam int MAG_W  = COORD_W;
  localparam int PROD_W = 2 * MAG_W;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic REG_NEIGHBOR_COUNT = 1'b0;
  localparam logic REG_POINT_COUNT    = 1'b1;

  localparam logic [NCOUNT_W-1:0] NCOUNT_RESET = NCOUNT_W'(4);
  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = '0;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Input opcodes.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic clear;
    logic insert;
  } list_ctl_t;

endpackage

// ===== design/k_nearest_neighbor_select_core.sv =====
// ----------------------------------------------------------------------------
// k_nearest_neighbor_select_core: brute-force 3D k-nearest-neighbor search
// Loads write points into an on-chip store; a query scans the store and
// returns the nearest neighbors of one stored point, nearest first.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                   Content of one beat
//   -------   -------------------------   ------------------------------------
//   in        in_valid / in_ready         load (slot + x,y,z) or query (slot)
//   out       out_valid / out_ready       one neighbor: index, distance, rank
//   config    psel/penable/pwrite/pready  neighbor_count @0x0, point_count @0x4
//
// A load beat is written straight into the store and leaves the core idle.
// During a query each scanned point costs a store read and the four steps of
// the shared multiplier and accumulator; the query slot itself is skipped
// without a store read. Before the scan, a query slot at or above MAX_POINTS
// is reduced by one subtraction per cycle. Reset clears control state only;
// the point store holds no valid bits and needs no clearing pass. A low
// out_ready stalls result emission and holds the input side not ready until
// the query's results are all in the output stage.
module k_nearest_neighbor_select_core #(
  parameter int MAX_POINTS    = knn_sel_pkg::MAX_POINTS_DEF,
  parameter int MAX_NEIGHBORS = knn_sel_pkg::MAX_NEIGHBORS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // Input channel
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic                                       action,
  input  logic [knn_sel_pkg::INDEX_W-1:0]            point_index,
  input  logic signed [knn_sel_pkg::COORD_W-1:0]     coord_x,
  input  logic signed [knn_sel_pkg::COORD_W-1:0]     coord_y,
  input  logic signed [knn_sel_pkg::COORD_W-1:0]     coord_z,
  input  logic [knn_sel_pkg::INDEX_W-1:0]            query_index,
  // Result channel
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic [knn_sel_pkg::INDEX_W-1:0]            neighbor_index,
  output logic [knn_sel_pkg::DIST_W-1:0]             distance_squared,
  output logic [knn_sel_pkg::RANK_W-1:0]             rank,
  output logic                                       last_result,
  output logic                                       too_few_points,
  // Configuration port
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [knn_sel_pkg::APB_ADDR_W-1:0]         paddr,
  input  logic [knn_sel_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [knn_sel_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                       pready
);

  // Store address, scan counter and comparison widths all follow the sizes.
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int PW  = (PCW > knn_sel_pkg::PCOUNT_W) ? PCW : knn_sel_pkg::PCOUNT_W;
  localparam int KCW = $clog2(MAX_NEIGHBORS + 1);
  localparam int KW  = (KCW > knn_sel_pkg::NCOUNT_W) ? KCW : knn_sel_pkg::NCOUNT_W;
  localparam int RIW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int CW  = (PCW > knn_sel_pkg::COUNT_W) ? PCW : knn_sel_pkg::COUNT_W;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_QMOD   = 8'b0000_0010,
    ST_QREAD  = 8'b0000_0100,
    ST_QLATCH = 8'b0000_1000,
    ST_SCAN   = 8'b0001_0000,
    ST_FETCH  = 8'b0010_0000,
    ST_DIST   = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // --------------------------------------------------------------------------
  // Configuration registers. The register index is taken from address bit 2,
  // so every address within the window lands on one of the two registers.
  // --------------------------------------------------------------------------
  logic [knn_sel_pkg::NCOUNT_W-1:0] neighbor_count;
  logic [knn_sel_pkg::PCOUNT_W-1:0] point_count;
  logic                             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_count <= knn_sel_pkg::NCOUNT_RESET;
      point_count    <= knn_sel_pkg::PCOUNT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        knn_sel_pkg::REG_NEIGHBOR_COUNT: neighbor_count <= pwdata[knn_sel_pkg::NCOUNT_W-1:0];
        knn_sel_pkg::REG_POINT_COUNT:    point_count    <= pwdata[knn_sel_pkg::PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      knn_sel_pkg::REG_NEIGHBOR_COUNT: prdata = knn_sel_pkg::APB_DATA_W'(neighbor_count);
      knn_sel_pkg::REG_POINT_COUNT:    prdata = knn_sel_pkg::APB_DATA_W'(point_count);
      default:                         prdata = '0;
    endcase
  end

  // Clamp the registers into the ranges the hardware supports. A neighbor
  // count of zero behaves as one.
  logic [KCW-1:0] k_clamped;
  logic [PCW-1:0] n_clamped;

  always_comb begin
    if (neighbor_count == '0) begin
      k_clamped = KCW'(1);
    end else if (KW'(neighbor_count) > KW'(MAX_NEIGHBORS)) begin
      k_clamped = KCW'(MAX_NEIGHBORS);
    end else begin
      k_clamped = KCW'(neighbor_count);
    end
    if (PW'(point_count) > PW'(MAX_POINTS)) begin
      n_clamped = PCW'(MAX_POINTS);
    end else begin
      n_clamped = PCW'(point_count);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  logic                   in_fire;
  logic                   is_query;
  logic [KCW-1:0]         k_eff;
  logic [PCW-1:0]         n_eff;
  logic [PW-1:0]          qrem;
  logic [PCW-1:0]         p;
  logic [RIW-1:0]         r;
  logic [AW-1:0]          q_addr;
  logic [AW-1:0]          scan_addr;
  logic                   qrem_big;
  logic                   scan_done;
  logic                   scan_skip;
  logic                   out_free;
  logic                   r_last;
  logic                   rank_filled;
  knn_sel_pkg::point_t    query_pt;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_query  = (action == knn_sel_pkg::ACT_QUERY);
  assign q_addr    = AW'(qrem);
  assign scan_addr = AW'(p);
  assign qrem_big  = (qrem >= PW'(MAX_POINTS));
  assign scan_done = (p >= n_eff);
  // The query's own slot is only ever matched inside the scanned range.
  assign scan_skip = (scan_addr == q_addr);
  assign out_free  = !out_valid || out_ready;
  assign r_last    = (KCW'(r) == (k_eff - KCW'(1)));

  // --------------------------------------------------------------------------
  // Point store
  // --------------------------------------------------------------------------
  logic                 st_wr_en;
  logic [AW-1:0]        st_wr_addr;
  knn_sel_pkg::point_t  st_wr_data;
  logic                 st_rd_en;
  logic [AW-1:0]        st_rd_addr;
  knn_sel_pkg::point_t  st_rd_data;

  // Loads beyond the store are dropped.
  assign st_wr_en   = in_fire && !is_query && (PW'(point_index) < PW'(MAX_POINTS));
  assign st_wr_addr = AW'(point_index);
  assign st_wr_data = '{x: coord_x, y: coord_y, z: coord_z};
  assign st_rd_en   = (state == ST_QREAD) || ((state == ST_SCAN) && !scan_done && !scan_skip);
  assign st_rd_addr = (state == ST_QREAD) ? q_addr : scan_addr;

  knn_sel_store #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // --------------------------------------------------------------------------
  // Shared distance unit: started when the candidate's coordinates arrive
  // from the store, it steps through x, y and z and reports one squared distance.
  // --------------------------------------------------------------------------
  logic                            dist_done;
  logic [knn_sel_pkg::DIST_W-1:0]  dist_value;

  knn_sel_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .start   (state == ST_FETCH),
    .point_a (query_pt),
    .point_b (st_rd_data),
    .done    (dist_done),
    .sq_dist (dist_value)
  );

  // --------------------------------------------------------------------------
  // Best-k list: cleared as a query is accepted, fed one candidate per
  // finished distance, read by rank while results are emitted.
  // --------------------------------------------------------------------------
  knn_sel_pkg::list_ctl_t            list_ctl;
  logic [knn_sel_pkg::DIST_W-1:0]    list_rd_dist;
  logic [knn_sel_pkg::INDEX_W-1:0]   list_rd_index;
  logic [knn_sel_pkg::COUNT_W-1:0]   list_count;

  assign list_ctl.clear  = in_fire && is_query;
  assign list_ctl.insert = (state == ST_DIST) && dist_done;

  knn_sel_list #(
    .DEPTH (MAX_NEIGHBORS),
    .KCW   (KCW),
    .RIW   (RIW)
  ) u_list (
    .clk        (clk),
    .rst        (rst),
    .ctl        (list_ctl),
    .k_eff      (k_eff),
    .cand_dist  (dist_value),
    .cand_index (knn_sel_pkg::INDEX_W'(p)),
    .rd_rank    (r),
    .rd_dist    (list_rd_dist),
    .rd_index   (list_rd_index),
    .count      (list_count)
  );

  assign rank_filled = (knn_sel_pkg::COUNT_W'(r) < list_count);

  // --------------------------------------------------------------------------
  // State machine
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_fire && is_query) state_next = ST_QMOD;
      ST_QMOD:   if (!qrem_big) state_next = ST_QREAD;
      ST_QREAD:  state_next = ST_QLATCH;
      ST_QLATCH: state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_EMIT;
        end else if (!scan_skip) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH:  state_next = ST_DIST;
      ST_DIST:   if (dist_done) state_next = ST_SCAN;
      ST_EMIT:   if (out_free && r_last) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      k_eff     <= KCW'(1);
      n_eff     <= '0;
      qrem      <= '0;
      p         <= '0;
      r         <= '0;
    end else begin
      state <= state_next;
      // The output stage is refilled whenever it frees up during emission.
      if ((state == ST_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire && is_query) begin
            qrem  <= PW'(query_index);
            k_eff <= k_clamped;
            n_eff <= n_clamped;
          end
        end
        ST_QMOD: begin
          if (qrem_big) begin
            qrem <= qrem - PW'(MAX_POINTS);
          end
        end
        ST_QLATCH: begin
          p <= '0;
          r <= '0;
        end
        ST_SCAN: begin
          if (!scan_done && scan_skip) begin
            p <= p + PCW'(1);
          end
        end
        ST_DIST: begin
          if (dist_done) begin
            p <= p + PCW'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            r <= r + RIW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers: the query point and the output stage.
  always_ff @(posedge clk) begin
    if (state == ST_QLATCH) begin
      query_pt <= st_rd_data;
    end
    if ((state == ST_EMIT) && out_free) begin
      // Ranks beyond the number of candidates found report zeros.
      neighbor_index   <= rank_filled ? list_rd_index : '0;
      distance_squared <= rank_filled ? list_rd_dist : '0;
      rank             <= knn_sel_pkg::RANK_W'(r);
      last_result      <= r_last;
      too_few_points   <= (list_count < knn_sel_pkg::COUNT_W'(k_eff));
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_last_beat: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && out_free && r_last |=> out_valid && last_result)
    else $error("final rank did not produce a last beat");

  a_dist_window: assert property (@(posedge clk) disable iff (rst)
    dist_done |-> (state == ST_DIST))
    else $error("distance finished outside the wait state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(list_count) <= CW'(p))
    else $error("more insertions than scanned points");
`endif

endmodule

// ===== design/knn_sel_store.sv =====
// ----------------------------------------------------------------------------
// knn_sel_store: point memory
// One write port and one registered read port holding x, y, z per slot.
// ----------------------------------------------------------------------------
module knn_sel_store #(
  parameter int DEPTH = knn_sel_pkg::MAX_POINTS_DEF,
  parameter int AW    = 12
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  knn_sel_pkg::point_t  wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output knn_sel_pkg::point_t  rd_data
);

  knn_sel_pkg::point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/knn_sel_dist.sv =====
// ----------------------------------------------------------------------------
// knn_sel_dist: squared-distance unit
// One multiplier squares the three coordinate differences in turn and an
// adder accumulates them.
// ----------------------------------------------------------------------------
module knn_sel_dist (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  knn_sel_pkg::point_t                  point_a,
  input  knn_sel_pkg::point_t                  point_b,
  output logic                                 done,
  output logic [knn_sel_pkg::DIST_W-1:0]       sq_dist
);

  function automatic logic [knn_sel_pkg::MAG_W-1:0] abs_diff(
    input logic signed [knn_sel_pkg::COORD_W-1:0] a,
    input logic signed [knn_sel_pkg::COORD_W-1:0] b
  );
    logic signed [knn_sel_pkg::COORD_W:0] d;
    d = $signed({a[knn_sel_pkg::COORD_W-1], a}) - $signed({b[knn_sel_pkg::COORD_W-1], b});
    return d[knn_sel_pkg::COORD_W] ? knn_sel_pkg::MAG_W'(-d) : knn_sel_pkg::MAG_W'(d);
  endfunction

  logic [knn_sel_pkg::MAG_W-1:0]  mag_x;
  logic [knn_sel_pkg::MAG_W-1:0]  mag_y;
  logic [knn_sel_pkg::MAG_W-1:0]  mag_z;
  logic [knn_sel_pkg::MAG_W-1:0]  mag_sel;
  logic [knn_sel_pkg::PROD_W-1:0] prod;
  logic [knn_sel_pkg::DIST_W-1:0] acc;
  logic [1:0]                     step;
  logic                           busy;

  // Step 0..2 squares x, y, z; steps 1..3 add the previous product.
  always_comb begin
    unique case (step)
      2'd0:    mag_sel = mag_x;
      2'd1:    mag_sel = mag_y;
      2'd2:    mag_sel = mag_z;
      default: mag_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_x <= abs_diff(point_a.x, point_b.x);
      mag_y <= abs_diff(point_a.y, point_b.y);
      mag_z <= abs_diff(point_a.z, point_b.z);
      acc   <= '0;
    end else if (busy) begin
      if (step != 2'd3) begin
        prod <= mag_sel * mag_sel;
      end
      if (step != 2'd0) begin
        acc <= acc + knn_sel_pkg::DIST_W'(prod);
      end
    end
  end

  assign sq_dist = acc;

endmodule

// ===== design/knn_sel_list.sv =====
// ----------------------------------------------------------------------------
// knn_sel_list: sorted best-k list
// A row of cells that each compare the candidate against their own entry and
// take either the candidate or their upper neighbor's entry.
// ----------------------------------------------------------------------------
module knn_sel_list #(
  parameter int DEPTH = knn_sel_pkg::MAX_NEIGHBORS_DEF,
  parameter int KCW   = 5,
  parameter int RIW   = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  knn_sel_pkg::list_ctl_t               ctl,
  input  logic [KCW-1:0]                       k_eff,
  input  logic [knn_sel_pkg::DIST_W-1:0]       cand_dist,
  input  logic [knn_sel_pkg::INDEX_W-1:0]      cand_index,
  input  logic [RIW-1:0]                       rd_rank,
  output logic [knn_sel_pkg::DIST_W-1:0]       rd_dist,
  output logic [knn_sel_pkg::INDEX_W-1:0]      rd_index,
  output logic [knn_sel_pkg::COUNT_W-1:0]      count
);

  logic [knn_sel_pkg::DIST_W-1:0]  dist_q  [DEPTH];
  logic [knn_sel_pkg::INDEX_W-1:0] index_q [DEPTH];
  logic [DEPTH-1:0]                less;

  // The list is sorted, so the set of cells the candidate beats is a tail.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      less[i] = (KCW'(i) < k_eff) && (cand_dist < dist_q[i]);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (rst || ctl.clear) begin
          dist_q[g]  <= '1;
          index_q[g] <= '0;
        end else if (ctl.insert && less[g]) begin
          dist_q[g]  <= cand_dist;
          index_q[g] <= cand_index;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (rst || ctl.clear) begin
          dist_q[g]  <= '1;
          index_q[g] <= '0;
        end else if (ctl.insert && less[g]) begin
          if (less[g-1]) begin
            dist_q[g]  <= dist_q[g-1];
            index_q[g] <= index_q[g-1];
          end else begin
            dist_q[g]  <= cand_dist;
            index_q[g] <= cand_index;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      count <= '0;
    end else if (ctl.insert && (|less) && (count != knn_sel_pkg::COUNT_MAX)) begin
      count <= count + knn_sel_pkg::COUNT_W'(1);
    end
  end

  assign rd_dist  = dist_q[rd_rank];
  assign rd_index = index_q[rd_rank];

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the k-nearest-neighbor selector core
// Streams point loads and neighbor queries into the core and reprograms both
// count registers between phases. A built-in predictor ranks the scanned
// points per query and checks each result beat, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int COORD_MAX = 8388607;
  localparam int COORD_MIN = -8388608;

  // One input beat as the driver presents it. Fields that the opcode does not
  // use still carry random data so that the core is seen to ignore them.
  typedef struct packed {
    logic                            act;
    logic [knn_sel_pkg::INDEX_W-1:0] slot;
    knn_sel_pkg::point_t             pt;
    logic [knn_sel_pkg::INDEX_W-1:0] qslot;
  } point_op_t;

  // One predicted result beat.
  typedef struct packed {
    logic [knn_sel_pkg::INDEX_W-1:0] index;
    logic [knn_sel_pkg::DIST_W-1:0]  span_sq;
    logic [knn_sel_pkg::RANK_W-1:0]  rank;
    logic                            is_last;
    logic                            too_few;
  } neighbor_t;

  // Clock, reset and every core input start at a known value.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                   in_valid    = 1'b0;
  logic                                   in_ready;
  logic                                   action      = knn_sel_pkg::ACT_LOAD;
  logic [knn_sel_pkg::INDEX_W-1:0]        point_index = '0;
  logic signed [knn_sel_pkg::COORD_W-1:0] coord_x     = '0;
  logic signed [knn_sel_pkg::COORD_W-1:0] coord_y     = '0;
  logic signed [knn_sel_pkg::COORD_W-1:0] coord_z     = '0;
  logic [knn_sel_pkg::INDEX_W-1:0]        query_index = '0;

  logic                                   out_valid;
  logic                                   out_ready   = 1'b0;
  logic [knn_sel_pkg::INDEX_W-1:0]        neighbor_index;
  logic [knn_sel_pkg::DIST_W-1:0]         distance_squared;
  logic [knn_sel_pkg::RANK_W-1:0]         rank;
  logic                                   last_result;
  logic                                   too_few_points;

  logic                               psel    = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite  = 1'b0;
  logic [knn_sel_pkg::APB_ADDR_W-1:0] paddr   = '0;
  logic [knn_sel_pkg::APB_DATA_W-1:0] pwdata  = '0;
  logic [knn_sel_pkg::APB_DATA_W-1:0] prdata;
  logic                               pready;

  // Beats waiting to be driven, and result beats the predictor expects.
  point_op_t op_queue[$];
  neighbor_t pending_neighbors[$];

  // The predictor's own copy of the point store and of both registers.
  knn_sel_pkg::point_t               point_mem [knn_sel_pkg::MAX_POINTS_DEF];
  logic [knn_sel_pkg::NCOUNT_W-1:0]  neighbors_cfg = knn_sel_pkg::NCOUNT_RESET;
  logic [knn_sel_pkg::PCOUNT_W-1:0]  points_cfg    = knn_sel_pkg::PCOUNT_RESET;

  // Percent chance per cycle that the sender idles or the receiver stalls.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int fault_count   = 0;

  always #10 clk = ~clk;

  k_nearest_neighbor_select_core DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .point_index      (point_index),
    .coord_x          (coord_x),
    .coord_y          (coord_y),
    .coord_z          (coord_z),
    .query_index      (query_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .neighbor_index   (neighbor_index),
    .distance_squared (distance_squared),
    .rank             (rank),
    .last_result      (last_result),
    .too_few_points   (too_few_points),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // --------------------------------------------------------------------------
  // Predictor. Brute-force ranking of the scanned slots by squared distance to
  // the query point. The best list is kept sorted and a candidate only moves
  // in on a strict less-than, so the earlier slot wins a tie. The insertion
  // count saturates like the hardware counter, and ranks beyond it report a
  // zero index and zero distance with the too-few flag raised on every beat.
  // --------------------------------------------------------------------------
  function automatic void rank_neighbors(logic [knn_sel_pkg::INDEX_W-1:0] qslot);
    logic [knn_sel_pkg::DIST_W-1:0]  best_span [knn_sel_pkg::MAX_NEIGHBORS_DEF];
    logic [knn_sel_pkg::INDEX_W-1:0] best_slot [knn_sel_pkg::MAX_NEIGHBORS_DEF];
    logic [knn_sel_pkg::DIST_W-1:0]  span;
    logic [63:0]                     sum;
    longint                          dx, dy, dz;
    int                              k, n, q, inserted;
    bit                              placed;
    neighbor_t                       nb;
    // Out-of-range register values are clamped the way the core clamps them.
    if (neighbors_cfg == 0) k = 1;
    else if (neighbors_cfg > knn_sel_pkg::MAX_NEIGHBORS_DEF)
      k = knn_sel_pkg::MAX_NEIGHBORS_DEF;
    else k = int'(neighbors_cfg);
    n = (points_cfg > knn_sel_pkg::MAX_POINTS_DEF) ? knn_sel_pkg::MAX_POINTS_DEF
                                                   : int'(points_cfg);
    q = int'(qslot) % knn_sel_pkg::MAX_POINTS_DEF;
    for (int j = 0; j < knn_sel_pkg::MAX_NEIGHBORS_DEF; j++) begin
      best_span[j] = '1;
      best_slot[j] = '0;
    end
    inserted = 0;
    for (int p = 0; p < n; p++) begin
      if (p != q) begin
        dx = longint'($signed(point_mem[q].x)) - longint'($signed(point_mem[p].x));
        dy = longint'($signed(point_mem[q].y)) - longint'($signed(point_mem[p].y));
        dz = longint'($signed(point_mem[q].z)) - longint'($signed(point_mem[p].z));
        sum = 64'(dx * dx + dy * dy + dz * dz);
        span = sum[knn_sel_pkg::DIST_W-1:0];
        placed = 1'b0;
        for (int j = 0; j < k; j++) begin
          if (!placed && span < best_span[j]) begin
            for (int i = k - 1; i > j; i--) begin
              best_span[i] = best_span[i-1];
              best_slot[i] = best_slot[i-1];
            end
            best_span[j] = span;
            best_slot[j] = knn_sel_pkg::INDEX_W'(p);
            if (inserted < int'(knn_sel_pkg::COUNT_MAX)) inserted++;
            placed = 1'b1;
          end
        end
      end
    end
    for (int r = 0; r < k; r++) begin
      nb.index   = (r < inserted) ? best_slot[r] : '0;
      nb.span_sq = (r < inserted) ? best_span[r] : '0;
      nb.rank    = knn_sel_pkg::RANK_W'(r);
      nb.is_last = (r == k - 1);
      nb.too_few = (inserted < k);
      pending_neighbors.insert(pending_neighbors.size(), nb);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input driver. A beat accepted at this edge updates the predictor: a load
  // writes the model store, a query produces its expected results. A new beat
  // is only presented when the channel is free, so valid and the payload hold
  // steady while the core back-pressures.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    point_op_t op;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (action == knn_sel_pkg::ACT_LOAD)
          point_mem[point_index] = {coord_x, coord_y, coord_z};
        else rank_neighbors(query_index);
      end
      if (!in_valid || in_ready) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          op = op_queue.pop_front();
          in_valid    <= 1'b1;
          action      <= op.act;
          point_index <= op.slot;
          coord_x     <= op.pt.x;
          coord_y     <= op.pt.y;
          coord_z     <= op.pt.z;
          query_index <= op.qslot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Every accepted result beat is matched against the oldest
  // prediction; a beat with nothing predicted is a failure too. Only the first
  // ten failures are printed, the rest are counted.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    neighbor_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_neighbors.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected result beat: neighbor_index %0d distance %0d rank %0d",
                     neighbor_index, distance_squared, rank);
        end else begin
          want = pending_neighbors.pop_front();
          if (want.index !== neighbor_index || want.span_sq !== distance_squared ||
              want.rank !== rank || want.is_last !== last_result ||
              want.too_few !== too_few_points) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("mismatch exp: index %0d dist %0d rank %0d last %0b few %0b",
                       want.index, want.span_sq, want.rank, want.is_last, want.too_few);
              $display("         got: index %0d dist %0d rank %0d last %0b few %0b",
                       neighbor_index, distance_squared, rank, last_result,
                       too_few_points);
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic knn_sel_pkg::point_t mk_point(int x, int y, int z);
    knn_sel_pkg::point_t p;
    p.x = knn_sel_pkg::COORD_W'(x);
    p.y = knn_sel_pkg::COORD_W'(y);
    p.z = knn_sel_pkg::COORD_W'(z);
    return p;
  endfunction

  // Mostly small coordinates so that equal distances are common, plus full
  // random values and the two extremes of the coordinate range.
  function automatic knn_sel_pkg::point_t rand_point();
    logic signed [knn_sel_pkg::COORD_W-1:0] c [3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(7))
        0, 1:    c[i] = knn_sel_pkg::COORD_W'($urandom);
        2:       c[i] = $urandom_range(1) ? knn_sel_pkg::COORD_W'(COORD_MAX)
                                          : knn_sel_pkg::COORD_W'(COORD_MIN);
        default: c[i] = knn_sel_pkg::COORD_W'(int'($urandom_range(16)) - 8);
      endcase
    end
    return mk_point(c[0], c[1], c[2]);
  endfunction

  task automatic push_load(int slot, knn_sel_pkg::point_t pt);
    point_op_t op;
    op.act   = knn_sel_pkg::ACT_LOAD;
    op.slot  = knn_sel_pkg::INDEX_W'(slot);
    op.pt    = pt;
    op.qslot = knn_sel_pkg::INDEX_W'($urandom);
    op_queue.insert(op_queue.size(), op);
  endtask

  task automatic push_query(int q);
    point_op_t op;
    op.act   = knn_sel_pkg::ACT_QUERY;
    op.slot  = knn_sel_pkg::INDEX_W'($urandom);
    op.pt    = mk_point(int'($urandom), int'($urandom), int'($urandom));
    op.qslot = knn_sel_pkg::INDEX_W'(q);
    op_queue.insert(op_queue.size(), op);
  endtask

  // Wait until every queued beat is accepted and every predicted result has
  // come back. The check runs on the falling edge so it never races the
  // driver. The task then waits on so that a trailing load, which returns
  // nothing, can settle inside the core.
  task automatic wait_quiet();
    @(negedge clk);
    while (op_queue.size() != 0 || in_valid || pending_neighbors.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Register write in two phases: setup, then access with penable high.
  task automatic write_reg(logic idx, int value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= knn_sel_pkg::APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == knn_sel_pkg::REG_NEIGHBOR_COUNT)
      neighbors_cfg = knn_sel_pkg::NCOUNT_W'(value);
    else points_cfg = knn_sel_pkg::PCOUNT_W'(value);
  endtask

  // Registers are only touched once the core has drained.
  task automatic set_config(int k, int n);
    wait_quiet();
    write_reg(knn_sel_pkg::REG_NEIGHBOR_COUNT, k);
    write_reg(knn_sel_pkg::REG_POINT_COUNT, n);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : sequence_main
    int cur_n, pick;
    int send_mode [4];
    int stall_mode [4];
    send_mode  = '{0, 86, 0, 13};
    stall_mode = '{0, 0, 86, 13};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, no idling. First a query under the reset register values:
    // with no points scanned, all four ranks come back empty.
    push_load(0, mk_point(COORD_MAX, COORD_MAX, COORD_MAX));
    push_query(0);

    // Six scanned points: both corners of the coordinate cube for the largest
    // possible distance, a duplicate pair for a zero distance, and two points
    // at equal distance from the origin to check that the earlier slot wins.
    set_config(3, 6);
    push_load(0, mk_point(COORD_MAX, COORD_MAX, COORD_MAX));
    push_load(1, mk_point(COORD_MIN, COORD_MIN, COORD_MIN));
    push_load(2, mk_point(0, 0, 0));
    push_load(3, mk_point(0, 0, 0));
    push_load(4, mk_point(1, 0, 0));
    push_load(5, mk_point(-1, 0, 0));
    push_load(4095, mk_point(0, 0, 1));
    push_query(2);
    push_query(0);
    push_query(1);
    // Query slot outside the scanned range, so no slot is skipped.
    push_query(4095);

    // A neighbor count above the maximum acts as the maximum: too few points.
    set_config(31, 6);
    push_query(3);
    // A neighbor count of zero acts as one.
    set_config(0, 6);
    push_query(5);
    // The only scanned slot is the query itself: no candidate at all.
    set_config(1, 1);
    push_query(0);

    // Fill slots up to 39, then scan all of them with the widest neighbor
    // list, once from inside the scanned range and once from the top slot.
    for (int s = 6; s < 40; s++) push_load(s, rand_point());
    set_config(knn_sel_pkg::MAX_NEIGHBORS_DEF, 40);
    push_query(int'($urandom_range(39)));
    push_query(4095);

    // Random part. Slots 0 to 39 and the top slot are written by now, so
    // queries stay among those. Each idling mode runs two register settings.
    for (int ph = 0; ph < 4; ph++) begin
      repeat (2) begin
        case ($urandom_range(4))
          0:       pick = 0;
          1:       pick = 1;
          2:       pick = knn_sel_pkg::MAX_NEIGHBORS_DEF;
          3:       pick = 31;
          default: pick = int'($urandom_range(knn_sel_pkg::MAX_NEIGHBORS_DEF - 1, 2));
        endcase
        cur_n = int'($urandom_range(38));
        set_config(pick, cur_n);
        send_idle_pct = send_mode[ph];
        stall_pct     = stall_mode[ph];
        repeat (11) begin
          if ($urandom_range(99) < 55) begin
            // Mostly near the scanned range, just past its end included.
            if ($urandom_range(4) == 0) push_query(4095);
            else push_query(int'($urandom_range(cur_n + 1)));
          end else begin
            if ($urandom_range(4) == 0)
              push_load(int'($urandom_range(knn_sel_pkg::MAX_POINTS_DEF - 1)),
                        rand_point());
            else
              push_load(int'($urandom_range(cur_n + 2)), rand_point());
          end
        end
      end
    end

    // Drain, then watch a little longer for stray result beats.
    wait_quiet();
    repeat (40) @(posedge clk);
    if (fault_count == 0 && pending_neighbors.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, dominated by the widest
  // scans and the heavily stalled phases.
  initial begin : watchdog
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
